[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the pinwheel subdivider.
// No dependencies; define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("invariant violated");

// antecedent at one edge implies consequent at the next
`define ASSERT_IMPLIES_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cycle-to-cycle check violated");

`else

`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_IMPLIES_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[rtl/pts_pkg.sv]
// Types, constants and arithmetic helpers for the pinwheel subdivider.
// No dependencies; used by pinwheel_triangle_subdivider_unit.
package pts_pkg;

  // signed fixed point, 16 fraction bits
  typedef logic signed [23:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  // squared difference of two coordinates (at most 2^48)
  typedef logic [48:0] sq_t;
  // biased quotient from the divide-by-five unit
  typedef logic [25:0] quo_t;
  // sum of three squares
  typedef logic [50:0] sqsum_t;

  // emission order of the five children
  typedef enum logic [2:0] {
    CHILD_0 = 3'd0,
    CHILD_1 = 3'd1,
    CHILD_2 = 3'd2,
    CHILD_3 = 3'd3,
    CHILD_4 = 3'd4
  } child_t;

  // x = q + 5*2^25 keeps the dividend positive and below 2^28
  localparam logic [27:0] FIFTH_OFS   = 28'd167772160;
  // ceil(2^31 / 5): exact floor(x/5) for every x below 2^28
  localparam logic [28:0] FIFTH_RECIP = 29'd429496730;
  localparam int          FIFTH_SHIFT = 31;
  // floor(FIFTH_OFS / 5) removed again after the division
  localparam quo_t        QUO_BIAS    = 26'd33554432;

  // (a - b)^2 on raw coordinates
  function automatic sq_t sq_diff(coord_t a, coord_t b);
    logic signed [24:0] d;
    logic signed [49:0] p;
    d = {a[23], a} - {b[23], b};
    p = d * d;
    return p[48:0];
  endfunction

  // floor((k*(b - a) + 2) / 5) + 2^25, k = 2 when dbl else 1;
  // equals round(k*(b - a)/5) plus the bias
  function automatic quo_t fifth_quo(coord_t a, coord_t b, logic dbl);
    logic signed [24:0] n;
    logic signed [26:0] q;
    logic [27:0]        x;
    logic [56:0]        p;
    n = {b[23], b} - {a[23], a};
    if (dbl) begin
      q = {n[24], n, 1'b0} + 27'd2;
    end else begin
      q = {n[24], n[24], n} + 27'd2;
    end
    x = {q[26], q} + FIFTH_OFS;
    p = x * FIFTH_RECIP;
    return p[56:FIFTH_SHIFT];
  endfunction

  // c + t or c - t, t being the unbiased quotient
  function automatic coord_t add_fifth(coord_t c, quo_t quo, logic sub);
    logic [25:0] t;
    logic [25:0] s;
    t = quo - QUO_BIAS;
    if (sub) begin
      s = {c[23], c[23], c} - t;
    end else begin
      s = {c[23], c[23], c} + t;
    end
    return s[23:0];
  endfunction

  // (a + b) >>> 1, rounds towards minus infinity
  function automatic coord_t mid_c(coord_t a, coord_t b);
    logic [24:0] s;
    s = {a[23], a} + {b[23], b};
    return s[24:1];
  endfunction

  function automatic vtx_t mid_v(vtx_t p, vtx_t q);
    vtx_t r;
    r.x = mid_c(p.x, q.x);
    r.y = mid_c(p.y, q.y);
    r.z = mid_c(p.z, q.z);
    return r;
  endfunction

endpackage

[rtl/pinwheel_triangle_subdivider_unit.sv]
// Pinwheel subdivider: one triangle in, five child triangles out.
// Depends on pts_pkg and assert_macros.svh.

// Each accepted triangle yields five child triangles, one per output transfer,
// so the sustained triangle rate is set by the single output register, which
// carries one child a cycle while out_ready does not stall it. An input
// transfer may happen in any cycle while a free slot remains in the four-stage
// pipe (input register, multiplier stage, compare stage, child stage), so up
// to three triangles queue behind the one being emitted. A triangle passes
// through the input register, multiplier stage, compare stage and child stage
// before its first child reaches the output register. Children come out in
// order 0..4, and last_child marks child 4.
`include "assert_macros.svh"

module pinwheel_triangle_subdivider_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pts_pkg::coord_t first_x,
  input  pts_pkg::coord_t first_y,
  input  pts_pkg::coord_t first_z,
  input  pts_pkg::coord_t second_x,
  input  pts_pkg::coord_t second_y,
  input  pts_pkg::coord_t second_z,
  input  pts_pkg::coord_t third_x,
  input  pts_pkg::coord_t third_y,
  input  pts_pkg::coord_t third_z,
  output logic          out_valid,
  input  logic          out_ready,
  output pts_pkg::coord_t out_a_x,
  output pts_pkg::coord_t out_a_y,
  output pts_pkg::coord_t out_a_z,
  output pts_pkg::coord_t out_b_x,
  output pts_pkg::coord_t out_b_y,
  output pts_pkg::coord_t out_b_z,
  output pts_pkg::coord_t out_c_x,
  output pts_pkg::coord_t out_c_y,
  output pts_pkg::coord_t out_c_z,
  output logic [2:0]    child_number,
  output logic          last_child
);

  import pts_pkg::*;

  // stage 1: input register
  logic   s1_valid;
  vtx_t   s1_v1, s1_v2, s1_v3;

  // stage 2: squares and fifth quotients
  logic   s2_valid;
  vtx_t   s2_v1, s2_v2, s2_v3;
  sq_t    s2_sq21 [3];
  sq_t    s2_sq32 [3];
  quo_t   s2_quo1 [3];
  quo_t   s2_quo2 [3];

  // stage 3: leg compare and candidate fifth points of both branches
  logic   s3_valid;
  logic   s3_less;
  vtx_t   s3_v1, s3_v2, s3_v3;
  vtx_t   s3_va_a, s3_vb_a, s3_va_b, s3_vb_b;

  // stage 4: child emitter
  logic   s4_valid;
  logic   s4_less;
  vtx_t   s4_v1, s4_v2, s4_v3, s4_va, s4_vb;
  child_t cnt;

  // handshake between stages
  logic   out_load, s4_done, s4_free, s3_free, s2_free, s1_free;

  // stage 3 combinational
  sqsum_t sum21, sum32;
  // stage 4 combinational
  vtx_t   vc, vd, child_a, child_b, child_c;

  vtx_t   in_v1, in_v2, in_v3;

  assign in_v1 = '{x: first_x,  y: first_y,  z: first_z};
  assign in_v2 = '{x: second_x, y: second_y, z: second_z};
  assign in_v3 = '{x: third_x,  y: third_y,  z: third_z};

  // stage flow: a stage is free when empty or when it hands on this cycle
  assign out_load = s4_valid && (!out_valid || out_ready);
  assign s4_done  = out_load && (cnt == CHILD_4);
  assign s4_free  = !s4_valid || s4_done;
  assign s3_free  = !s3_valid || s4_free;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;
  assign in_ready = s1_free;

  // leg lengths
  assign sum21 = sqsum_t'(s2_sq21[0]) + sqsum_t'(s2_sq21[1]) + sqsum_t'(s2_sq21[2]);
  assign sum32 = sqsum_t'(s2_sq32[0]) + sqsum_t'(s2_sq32[1]) + sqsum_t'(s2_sq32[2]);

  // inner points of the current triangle
  always_comb begin
    if (s4_less) begin
      vc = mid_v(s4_v2, s4_va);
      vd = mid_v(s4_v2, s4_v3);
    end else begin
      vc = mid_v(s4_v2, s4_vb);
      vd = mid_v(s4_v1, s4_v2);
    end
  end

  // child vertex selection
  always_comb begin
    child_a = s4_v2;
    child_b = s4_va;
    child_c = s4_v1;
    if (s4_less) begin
      case (cnt)
        CHILD_0: begin child_a = s4_v2; child_b = s4_va; child_c = s4_v1; end
        CHILD_1: begin child_a = vd;    child_b = vc;    child_c = s4_v2; end
        CHILD_2: begin child_a = s4_va; child_b = vc;    child_c = vd;    end
        CHILD_3: begin child_a = vd;    child_b = s4_vb; child_c = s4_va; end
        CHILD_4: begin child_a = s4_v3; child_b = s4_vb; child_c = vd;    end
        default: begin child_a = s4_v2; child_b = s4_va; child_c = s4_v1; end
      endcase
    end else begin
      case (cnt)
        CHILD_0: begin child_a = s4_v3; child_b = s4_vb; child_c = s4_v2; end
        CHILD_1: begin child_a = s4_v2; child_b = vc;    child_c = vd;    end
        CHILD_2: begin child_a = vd;    child_b = vc;    child_c = s4_vb; end
        CHILD_3: begin child_a = s4_vb; child_b = s4_va; child_c = vd;    end
        CHILD_4: begin child_a = vd;    child_b = s4_va; child_c = s4_v1; end
        default: begin child_a = s4_v3; child_b = s4_vb; child_c = s4_v2; end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= CHILD_0;
    end else begin
      if (s1_free) begin
        s1_valid <= in_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (s3_free) begin
        s3_valid <= s2_valid;
      end
      if (s4_free) begin
        s4_valid <= s3_valid;
      end
      if (s4_done) begin
        cnt <= CHILD_0;
      end else if (out_load) begin
        cnt <= child_t'(cnt + 3'd1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_v1 <= in_v1;
      s1_v2 <= in_v2;
      s1_v3 <= in_v3;
    end
  end

  // stage 2 payload: one multiplier per square and per fifth
  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2_v1      <= s1_v1;
      s2_v2      <= s1_v2;
      s2_v3      <= s1_v3;
      s2_sq21[0] <= sq_diff(s1_v2.x, s1_v1.x);
      s2_sq21[1] <= sq_diff(s1_v2.y, s1_v1.y);
      s2_sq21[2] <= sq_diff(s1_v2.z, s1_v1.z);
      s2_sq32[0] <= sq_diff(s1_v3.x, s1_v2.x);
      s2_sq32[1] <= sq_diff(s1_v3.y, s1_v2.y);
      s2_sq32[2] <= sq_diff(s1_v3.z, s1_v2.z);
      s2_quo1[0] <= fifth_quo(s1_v1.x, s1_v3.x, 1'b0);
      s2_quo1[1] <= fifth_quo(s1_v1.y, s1_v3.y, 1'b0);
      s2_quo1[2] <= fifth_quo(s1_v1.z, s1_v3.z, 1'b0);
      s2_quo2[0] <= fifth_quo(s1_v1.x, s1_v3.x, 1'b1);
      s2_quo2[1] <= fifth_quo(s1_v1.y, s1_v3.y, 1'b1);
      s2_quo2[2] <= fifth_quo(s1_v1.z, s1_v3.z, 1'b1);
    end
  end

  // stage 3 payload: compare legs, form fifth points for both branches
  always_ff @(posedge clk) begin
    if (s3_free && s2_valid) begin
      s3_v1     <= s2_v1;
      s3_v2     <= s2_v2;
      s3_v3     <= s2_v3;
      s3_less   <= (sum21 < sum32);
      // first leg shorter: va at 1/5, vb at 3/5 from v1
      s3_va_a.x <= add_fifth(s2_v1.x, s2_quo1[0], 1'b0);
      s3_va_a.y <= add_fifth(s2_v1.y, s2_quo1[1], 1'b0);
      s3_va_a.z <= add_fifth(s2_v1.z, s2_quo1[2], 1'b0);
      s3_vb_a.x <= add_fifth(s2_v3.x, s2_quo2[0], 1'b1);
      s3_vb_a.y <= add_fifth(s2_v3.y, s2_quo2[1], 1'b1);
      s3_vb_a.z <= add_fifth(s2_v3.z, s2_quo2[2], 1'b1);
      // mirrored placement
      s3_va_b.x <= add_fifth(s2_v1.x, s2_quo2[0], 1'b0);
      s3_va_b.y <= add_fifth(s2_v1.y, s2_quo2[1], 1'b0);
      s3_va_b.z <= add_fifth(s2_v1.z, s2_quo2[2], 1'b0);
      s3_vb_b.x <= add_fifth(s2_v3.x, s2_quo1[0], 1'b1);
      s3_vb_b.y <= add_fifth(s2_v3.y, s2_quo1[1], 1'b1);
      s3_vb_b.z <= add_fifth(s2_v3.z, s2_quo1[2], 1'b1);
    end
  end

  // stage 4 payload: pick the branch
  always_ff @(posedge clk) begin
    if (s4_free && s3_valid) begin
      s4_v1   <= s3_v1;
      s4_v2   <= s3_v2;
      s4_v3   <= s3_v3;
      s4_less <= s3_less;
      s4_va   <= s3_less ? s3_va_a : s3_va_b;
      s4_vb   <= s3_less ? s3_vb_a : s3_vb_b;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_a_x      <= child_a.x;
      out_a_y      <= child_a.y;
      out_a_z      <= child_a.z;
      out_b_x      <= child_b.x;
      out_b_y      <= child_b.y;
      out_b_z      <= child_b.z;
      out_c_x      <= child_c.x;
      out_c_y      <= child_c.y;
      out_c_z      <= child_c.z;
      child_number <= cnt;
      last_child   <= (cnt == CHILD_4);
    end
  end

  // checks
  `ASSERT_HOLDS(a_cnt_only_busy, clk, rst, (cnt == CHILD_0) || s4_valid)
  `ASSERT_HOLDS(a_last_tag, clk, rst, !out_valid || (last_child == (child_number == CHILD_4)))
  `ASSERT_IMPLIES_NEXT(a_child_cont, clk, rst, out_load && (cnt != CHILD_4), s4_valid && out_valid && !last_child)
  `ASSERT_IMPLIES_NEXT(a_drain, clk, rst, s4_done && !s3_valid, !s4_valid && (cnt == CHILD_0))

endmodule
